// ===== rtl/core/tcl_pkg.sv =====
// Shared types and constants for the tile cache core.
`timescale 1ns / 1ps
package tcl_pkg;
	localparam int CAPACITY = 64;
	localparam int COORD_BITS = 16;
	localparam int SLOT_BITS = $clog2(CAPACITY);
	localparam int USE_BITS = $clog2(CAPACITY + 1);
	localparam int STAMP_BITS = 32;

	typedef enum logic [1:0] {
		ST_DIRTY = 2'd0,
		ST_WORKING = 2'd1,
		ST_PAINTED = 2'd2
	} slot_state_t;

	typedef enum logic [2:0] {
		K_REQUEST = 3'd0,
		K_DISPATCH = 3'd1,
		K_PAINT_DONE = 3'd2,
		K_INVALIDATE = 3'd3,
		K_QUERY = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		OP_TOUCH,
		OP_DIRTY,
		OP_WORK,
		OP_PAINT,
		OP_STALE
	} op_t;

	typedef enum logic [1:0] {
		FS_IDLE,
		FS_SCAN,
		FS_DECIDE,
		FS_APPLY
	} fsm_t;

	localparam logic CFG_TILE_LIMIT = 1'b0;
	localparam logic CFG_PAINT_INLINE = 1'b1;

	typedef struct packed {
		logic [COORD_BITS-1:0] col;
		logic [COORD_BITS-1:0] row;
		logic [1:0] state;
		logic stale;
		logic [STAMP_BITS-1:0] stamp;
	} slot_t;
endpackage

// ===== rtl/core/tile_cache_lru_dirty_queue_core.sv =====
// Top level of the tile cache: slot ring and its sequencer.
//
// Channel   Direction  Handshake               Payload
// command   in         start high, busy low    kind, tile_col, tile_row, done_slot
// result    out        valid, one cycle        slot_index .. paint_row
// config    in         cfg_valid and cfg_ready cfg_index, cfg_data
//
// The slots sit in a ring of cells that rotates one place per cycle while the
// sequencer scans or applies. Requests and dispatches take a scan pass, a
// decision step and an apply pass, skipped when nothing is written back; queries
// never apply. Paint done and invalidate take one apply pass; unused kinds none.
// Reset clears counters, state, flags; limit goes to 64; slots need none.
// The result is shown for one cycle and the receiver cannot stall it.
`timescale 1ns / 1ps
module tile_cache_lru_dirty_queue_core import tcl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [2:0] kind,
	input logic [COORD_BITS-1:0] tile_col,
	input logic [COORD_BITS-1:0] tile_row,
	input logic [5:0] done_slot,
	output logic valid,
	output logic [5:0] slot_index,
	output logic hit,
	output logic pixels_ready,
	output logic refused,
	output logic dispatched,
	output logic [COORD_BITS-1:0] paint_col,
	output logic [COORD_BITS-1:0] paint_row,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [6:0] cfg_data
);
	slot_t ring [CAPACITY];
	slot_t wb;
	logic shift;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == CAPACITY - 1) begin : g_tail
			tcl_cell u_cell (.clk(clk), .shift(shift), .prev(wb), .slot(ring[i]));
		end else begin : g_body
			tcl_cell u_cell (.clk(clk), .shift(shift), .prev(ring[i+1]), .slot(ring[i]));
		end
	end

	tcl_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.tile_col(tile_col),
		.tile_row(tile_row),
		.done_slot(done_slot),
		.valid(valid),
		.slot_index(slot_index),
		.hit(hit),
		.pixels_ready(pixels_ready),
		.refused(refused),
		.dispatched(dispatched),
		.paint_col(paint_col),
		.paint_row(paint_row),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.head(ring[0]),
		.wb(wb),
		.shift(shift)
	);
endmodule

// ===== rtl/core/tcl_cell.sv =====
// One slot cell of the rotating slot ring.
`timescale 1ns / 1ps
module tcl_cell import tcl_pkg::*; (
	input logic clk,
	input logic shift,
	input slot_t prev,
	output slot_t slot
);
	slot_t slot_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			slot_q <= prev;
		end
	end

	assign slot = slot_q;
endmodule

// ===== rtl/core/tcl_ctrl.sv =====
// Sequencer that scans the slot ring and writes back the selected slot, or marks every slot in use stale.
`timescale 1ns / 1ps
module tcl_ctrl import tcl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [2:0] kind,
	input logic [COORD_BITS-1:0] tile_col,
	input logic [COORD_BITS-1:0] tile_row,
	input logic [5:0] done_slot,
	output logic valid,
	output logic [5:0] slot_index,
	output logic hit,
	output logic pixels_ready,
	output logic refused,
	output logic dispatched,
	output logic [COORD_BITS-1:0] paint_col,
	output logic [COORD_BITS-1:0] paint_row,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [6:0] cfg_data,
	input slot_t head,
	output slot_t wb,
	output logic shift
);
	fsm_t state_q, state_nxt;
	logic [2:0] kind_q;
	logic [COORD_BITS-1:0] col_q, row_q;
	logic [SLOT_BITS-1:0] cnt_q, tgt_q;
	logic [USE_BITS-1:0] in_use_q, limit;
	logic [STAMP_BITS-1:0] tick_q;
	logic [6:0] limit_q;
	logic inline_q;
	op_t op_q;
	logic new_q;
	logic mf_q, mready_q, mstale_q;
	logic [SLOT_BITS-1:0] midx_q;
	logic pf_q, df_q, xf_q;
	logic [SLOT_BITS-1:0] pidx_q, didx_q, xidx_q;
	logic [STAMP_BITS-1:0] pst_q, dst_q, xst_q;
	logic [COORD_BITS-1:0] xcol_q, xrow_q;
	logic in_range, last, at_tgt, accept, apply_go;
	logic res_valid_q, res_hit_q, res_ready_q, res_ref_q, res_disp_q;
	logic [SLOT_BITS-1:0] res_idx_q;
	logic [COORD_BITS-1:0] res_col_q, res_row_q;

	assign cfg_ready = 1'b1;
	assign busy = (state_q != FS_IDLE);
	assign accept = start && !busy;
	assign limit = (limit_q > 7'(CAPACITY)) ? USE_BITS'(CAPACITY) : USE_BITS'(limit_q);
	assign in_range = {1'b0, cnt_q} < in_use_q;
	assign last = (cnt_q == SLOT_BITS'(CAPACITY - 1));
	assign at_tgt = (cnt_q == tgt_q);
	assign shift = (state_q == FS_SCAN) || (state_q == FS_APPLY);

	always_comb begin
		apply_go = 1'b0;
		if (kind_q == K_REQUEST) begin
			apply_go = mf_q || (in_use_q < limit) || pf_q || df_q;
		end else if (kind_q == K_DISPATCH) begin
			apply_go = xf_q;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			FS_IDLE: begin
				if (accept) begin
					case (kind)
						K_REQUEST, K_DISPATCH, K_QUERY: state_nxt = FS_SCAN;
						K_PAINT_DONE, K_INVALIDATE: state_nxt = FS_APPLY;
						default: state_nxt = FS_IDLE;
					endcase
				end
			end
			FS_SCAN: begin
				if (last) begin
					state_nxt = FS_DECIDE;
				end
			end
			FS_DECIDE: begin
				state_nxt = apply_go ? FS_APPLY : FS_IDLE;
			end
			FS_APPLY: begin
				if (last) begin
					state_nxt = FS_IDLE;
				end
			end
			default: state_nxt = FS_IDLE;
		endcase
	end

	always_comb begin
		wb = head;
		if (state_q == FS_APPLY) begin
			case (op_q)
				OP_TOUCH: begin
					if (at_tgt) begin
						wb.stamp = tick_q;
					end
				end
				OP_DIRTY: begin
					if (at_tgt) begin
						wb.stamp = tick_q;
						wb.col = col_q;
						wb.row = row_q;
						if (inline_q) begin
							wb.state = ST_PAINTED;
							wb.stale = 1'b0;
						end else begin
							wb.state = ST_DIRTY;
							wb.stale = new_q ? 1'b0 : head.stale;
						end
					end
				end
				OP_WORK: begin
					if (at_tgt) begin
						wb.state = ST_WORKING;
					end
				end
				OP_PAINT: begin
					if (at_tgt && in_range && head.state == ST_WORKING) begin
						wb.state = ST_PAINTED;
						wb.stale = 1'b0;
					end
				end
				OP_STALE: begin
					if (in_range) begin
						wb.stale = 1'b1;
					end
				end
				default: wb = head;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
			cnt_q <= '0;
			in_use_q <= '0;
			tick_q <= '0;
			limit_q <= 7'(CAPACITY);
			inline_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			res_valid_q <= 1'b0;
			if (cfg_valid) begin
				if (cfg_index == CFG_TILE_LIMIT) begin
					limit_q <= cfg_data;
				end else if (cfg_index == CFG_PAINT_INLINE) begin
					inline_q <= cfg_data[0];
				end
			end
			if (shift) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == FS_IDLE && accept && kind > 3'(K_QUERY)) begin
				res_valid_q <= 1'b1;
			end
			if (state_q == FS_DECIDE) begin
				if (!apply_go) begin
					res_valid_q <= 1'b1;
				end
				if (kind_q == K_REQUEST && mf_q == 1'b0 && in_use_q < limit) begin
					in_use_q <= in_use_q + 1'b1;
				end
			end
			if (state_q == FS_APPLY && last) begin
				res_valid_q <= 1'b1;
				if (op_q == OP_TOUCH || op_q == OP_DIRTY) begin
					tick_q <= tick_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FS_IDLE && accept) begin
			kind_q <= kind;
			col_q <= tile_col;
			row_q <= tile_row;
			tgt_q <= done_slot[SLOT_BITS-1:0];
			op_q <= (kind == K_INVALIDATE) ? OP_STALE : OP_PAINT;
			new_q <= 1'b0;
			mf_q <= 1'b0;
			pf_q <= 1'b0;
			df_q <= 1'b0;
			xf_q <= 1'b0;
			res_idx_q <= '0;
			res_hit_q <= 1'b0;
			res_ready_q <= 1'b0;
			res_ref_q <= 1'b0;
			res_disp_q <= 1'b0;
			res_col_q <= '0;
			res_row_q <= '0;
		end
		if (state_q == FS_SCAN && in_range) begin
			if (!mf_q && head.col == col_q && head.row == row_q) begin
				mf_q <= 1'b1;
				midx_q <= cnt_q;
				mready_q <= head.state == ST_PAINTED && !head.stale;
				mstale_q <= head.state == ST_PAINTED && head.stale;
			end
			if (head.state == ST_PAINTED && (!pf_q || head.stamp < pst_q)) begin
				pf_q <= 1'b1;
				pidx_q <= cnt_q;
				pst_q <= head.stamp;
			end
			if (head.state == ST_DIRTY && (!df_q || head.stamp < dst_q)) begin
				df_q <= 1'b1;
				didx_q <= cnt_q;
				dst_q <= head.stamp;
			end
			if (head.state == ST_DIRTY && (!xf_q || head.stamp > xst_q)) begin
				xf_q <= 1'b1;
				xidx_q <= cnt_q;
				xst_q <= head.stamp;
				xcol_q <= head.col;
				xrow_q <= head.row;
			end
		end
		if (state_q == FS_DECIDE) begin
			case (kind_q)
				K_REQUEST: begin
					op_q <= OP_DIRTY;
					res_ready_q <= inline_q;
					if (mf_q) begin
						tgt_q <= midx_q;
						res_idx_q <= midx_q;
						res_hit_q <= 1'b1;
						if (!mstale_q) begin
							op_q <= OP_TOUCH;
							res_ready_q <= mready_q;
						end
					end else if (in_use_q < limit) begin
						tgt_q <= in_use_q[SLOT_BITS-1:0];
						res_idx_q <= in_use_q[SLOT_BITS-1:0];
						new_q <= 1'b1;
					end else if (pf_q) begin
						tgt_q <= pidx_q;
						res_idx_q <= pidx_q;
					end else if (df_q) begin
						tgt_q <= didx_q;
						res_idx_q <= didx_q;
					end else begin
						res_ready_q <= 1'b0;
						res_ref_q <= 1'b1;
					end
				end
				K_DISPATCH: begin
					op_q <= OP_WORK;
					tgt_q <= xidx_q;
					if (xf_q) begin
						res_idx_q <= xidx_q;
						res_disp_q <= 1'b1;
						res_col_q <= xcol_q;
						res_row_q <= xrow_q;
					end
				end
				K_QUERY: begin
					if (mf_q) begin
						res_idx_q <= midx_q;
						res_hit_q <= 1'b1;
						res_ready_q <= mready_q;
					end
				end
				default: res_ref_q <= 1'b0;
			endcase
		end
	end

	assign valid = res_valid_q;
	assign slot_index = 6'(res_idx_q);
	assign hit = res_hit_q;
	assign pixels_ready = res_ready_q;
	assign refused = res_ref_q;
	assign dispatched = res_disp_q;
	assign paint_col = res_col_q;
	assign paint_row = res_row_q;
endmodule
